// ===== rtl/srl_pkg.sv =====
// Package for the setpoint ramp limiter: fixed field widths, the rate reset value,
// the lead limit, register indexes and result codes. No dependencies.

package srl_pkg;

  localparam int RATE_W     = 31;
  localparam int PERIOD_W   = 24;
  localparam int PROD_W     = RATE_W + PERIOD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int LEAD_LIMIT = 200;

  localparam logic [RATE_W-1:0] RATE_RESET = 31'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_FWD_ACCEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_DECEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BWD_ACCEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BWD_DECEL = 3'd3;

  typedef enum logic [2:0] {
    OUT_UNCHANGED = 3'd0,
    OUT_TARGET    = 3'd1,
    OUT_AWAY      = 3'd2,
    OUT_TOWARD    = 3'd3,
    OUT_ZERO      = 3'd4,
    OUT_HELD      = 3'd5
  } outcome_t;

endpackage

// ===== rtl/setpoint_ramp_limiter_core.sv =====
// Setpoint ramp limiter, top level: rate registers, step multipliers and the
// ramp decision with saturation. Depends on srl_pkg.
//
// Usage: each input transfer carries a target, the current setpoint, the
// measured speed and the elapsed period; exactly one result transfer follows
// with the new setpoint and an outcome code. Rates are written through the
// configuration channel (index 0..3, other indexes ignored); cfg_ready is
// always high. Rates should only be changed while the block is empty.
// Throughput: one item per cycle while the receiver takes each result.
// The first stage registers the item together with the four
// rate-by-period products; the second stage compares, selects and
// saturates into the result register.
// When the receiver stalls the result is held and the first stage still
// accepts one more item; further input waits until the result is taken.
// Reset: the rates return to 1.0 and both pipeline stages are emptied.

module setpoint_ramp_limiter_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srl_pkg::RATE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_WIDTH-1:0]       target_speed,
  input  logic signed [VALUE_WIDTH-1:0]       current_setpoint,
  input  logic signed [VALUE_WIDTH-1:0]       measured_speed,
  input  logic [srl_pkg::PERIOD_W-1:0]        elapsed_period,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [VALUE_WIDTH-1:0]       new_setpoint,
  output srl_pkg::outcome_t                   outcome
);

  import srl_pkg::*;

  localparam int STEP_W = PROD_W - FRAC_BITS;
  localparam int CW     = ((VALUE_WIDTH > STEP_W) ? VALUE_WIDTH : STEP_W) + 2;

  // Rate registers.
  logic [RATE_W-1:0] fwd_accel_rate;
  logic [RATE_W-1:0] fwd_decel_rate;
  logic [RATE_W-1:0] bwd_accel_rate;
  logic [RATE_W-1:0] bwd_decel_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_accel_rate <= RATE_RESET;
      fwd_decel_rate <= RATE_RESET;
      bwd_accel_rate <= RATE_RESET;
      bwd_decel_rate <= RATE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FWD_ACCEL: fwd_accel_rate <= cfg_data;
        REG_FWD_DECEL: fwd_decel_rate <= cfg_data;
        REG_BWD_ACCEL: bwd_accel_rate <= cfg_data;
        REG_BWD_DECEL: bwd_decel_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage one: item and step sizes.
  logic                          s1_valid;
  logic signed [VALUE_WIDTH-1:0] s1_target;
  logic signed [VALUE_WIDTH-1:0] s1_now;
  logic signed [VALUE_WIDTH-1:0] s1_meas;
  logic                          s1_no_step;
  logic [STEP_W-1:0]             s1_fa;
  logic [STEP_W-1:0]             s1_fd;
  logic [STEP_W-1:0]             s1_ba;
  logic [STEP_W-1:0]             s1_bd;

  logic [PROD_W-1:0] prod_fa;
  logic [PROD_W-1:0] prod_fd;
  logic [PROD_W-1:0] prod_ba;
  logic [PROD_W-1:0] prod_bd;

  logic s1_load;
  logic s2_load;

  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign s1_load  = in_valid && in_ready;

  assign prod_fa = PROD_W'(fwd_accel_rate) * PROD_W'(elapsed_period);
  assign prod_fd = PROD_W'(fwd_decel_rate) * PROD_W'(elapsed_period);
  assign prod_ba = PROD_W'(bwd_accel_rate) * PROD_W'(elapsed_period);
  assign prod_bd = PROD_W'(bwd_decel_rate) * PROD_W'(elapsed_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_target  <= target_speed;
      s1_now     <= current_setpoint;
      s1_meas    <= measured_speed;
      s1_no_step <= (elapsed_period == '0);
      s1_fa      <= prod_fa[PROD_W-1:FRAC_BITS];
      s1_fd      <= prod_fd[PROD_W-1:FRAC_BITS];
      s1_ba      <= prod_ba[PROD_W-1:FRAC_BITS];
      s1_bd      <= prod_bd[PROD_W-1:FRAC_BITS];
    end
  end

  // Stage two: decision at full width, then saturation.
  logic signed [CW-1:0] tgt_w, now_w, meas_w;
  logic signed [CW-1:0] fa_w, fd_w, ba_w, bd_w;
  logic signed [CW-1:0] err_w, lead_w, lim_w;
  logic signed [CW-1:0] hi_w, lo_w;
  logic signed [CW-1:0] nxt_w;
  logic signed [VALUE_WIDTH-1:0] setpoint_next;
  outcome_t outcome_next;

  assign lim_w = CW'(LEAD_LIMIT) <<< FRAC_BITS;
  assign hi_w  = signed'({{(CW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
  assign lo_w  = signed'({{(CW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}});

  always_comb begin
    tgt_w  = signed'({{(CW-VALUE_WIDTH){s1_target[VALUE_WIDTH-1]}}, s1_target});
    now_w  = signed'({{(CW-VALUE_WIDTH){s1_now[VALUE_WIDTH-1]}}, s1_now});
    meas_w = signed'({{(CW-VALUE_WIDTH){s1_meas[VALUE_WIDTH-1]}}, s1_meas});
    fa_w   = signed'({{(CW-STEP_W){1'b0}}, s1_fa});
    fd_w   = signed'({{(CW-STEP_W){1'b0}}, s1_fd});
    ba_w   = signed'({{(CW-STEP_W){1'b0}}, s1_ba});
    bd_w   = signed'({{(CW-STEP_W){1'b0}}, s1_bd});
    err_w  = tgt_w - now_w;
    lead_w = now_w - meas_w;

    nxt_w        = now_w;
    outcome_next = OUT_UNCHANGED;
    priority if (s1_no_step) begin
      nxt_w        = now_w;
      outcome_next = OUT_UNCHANGED;
    end else if (!s1_target[VALUE_WIDTH-1] && !s1_now[VALUE_WIDTH-1]) begin
      priority if (err_w > fa_w) begin
        if (lead_w > lim_w) begin
          nxt_w        = now_w;
          outcome_next = OUT_HELD;
        end else begin
          nxt_w        = now_w + fa_w;
          outcome_next = OUT_AWAY;
        end
      end else if (err_w < -fd_w) begin
        nxt_w        = now_w - fd_w;
        outcome_next = OUT_TOWARD;
      end else begin
        nxt_w        = tgt_w;
        outcome_next = OUT_TARGET;
      end
    end else if (!s1_target[VALUE_WIDTH-1]) begin
      // Target ahead of zero, setpoint below it: come up to zero first.
      if (err_w >= bd_w && -now_w > bd_w) begin
        nxt_w        = now_w + bd_w;
        outcome_next = OUT_TOWARD;
      end else begin
        nxt_w        = '0;
        outcome_next = OUT_ZERO;
      end
    end else if (now_w <= 0) begin
      priority if (err_w < -ba_w) begin
        if (lead_w < -lim_w) begin
          nxt_w        = now_w;
          outcome_next = OUT_HELD;
        end else begin
          nxt_w        = now_w - ba_w;
          outcome_next = OUT_AWAY;
        end
      end else if (err_w > bd_w) begin
        nxt_w        = now_w + bd_w;
        outcome_next = OUT_TOWARD;
      end else begin
        nxt_w        = tgt_w;
        outcome_next = OUT_TARGET;
      end
    end else begin
      if (err_w <= -fd_w && now_w > fd_w) begin
        nxt_w        = now_w - fd_w;
        outcome_next = OUT_TOWARD;
      end else begin
        nxt_w        = '0;
        outcome_next = OUT_ZERO;
      end
    end

    priority if (nxt_w > hi_w) begin
      setpoint_next = hi_w[VALUE_WIDTH-1:0];
    end else if (nxt_w < lo_w) begin
      setpoint_next = lo_w[VALUE_WIDTH-1:0];
    end else begin
      setpoint_next = nxt_w[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      new_setpoint <= setpoint_next;
      outcome      <= outcome_next;
    end
  end

  // A zero result code always carries a zero setpoint.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_ZERO |-> new_setpoint == '0)
    else $error("zero outcome with nonzero setpoint");

  // An item with no elapsed time comes out unchanged.
  assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_no_step |=> outcome == OUT_UNCHANGED && new_setpoint == $past(s1_now))
    else $error("zero period item was altered");

  // A held item keeps its setpoint.
  assert property (@(posedge clk) disable iff (rst)
    s2_load && outcome_next == OUT_HELD |=> new_setpoint == $past(s1_now))
    else $error("held item changed its setpoint");

  // The first stage never drops a waiting item.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid)
    else $error("stage one lost an item");

endmodule
